@@ sv/mfsk_pkg.sv @@
package mfsk_pkg;

  localparam int MAX_SPS = 64;
  localparam int PHASE_BITS = 32;
  localparam int TAB_BITS = 10;
  localparam int QUARTER = 256;
  localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
  localparam logic [63:0] ONE_Q30 = 64'd1 << 30;
  localparam logic [63:0] AMPLITUDE = 64'd32767;

  localparam logic [1:0] CFG_BPS = 2'd0;
  localparam logic [1:0] CFG_SPS = 2'd1;
  localparam logic [1:0] CFG_BW = 2'd2;

  typedef struct packed {
    logic [PHASE_BITS-1:0] inc;
    logic                  clamped;
  } mfsk_entry_t;

  typedef logic signed [15:0] qtab_t [0:QUARTER];

  function automatic logic [63:0] taylor_step(input logic [63:0] term, input logic [63:0] t2);
    taylor_step = (term * t2) >> 30;
  endfunction

  function automatic qtab_t build_qtab();
    qtab_t       tab;
    logic [63:0] t;
    logic [63:0] t2;
    logic [63:0] term;
    logic [63:0] sum;
    for (int r = 0; r <= QUARTER; r++) begin
      t = (HALF_PI_Q30 * 64'(r)) >> 8;
      t2 = (t * t) >> 30;
      term = t;
      sum = t;
      term = taylor_step(term, t2) / 6;   sum = sum - term;
      term = taylor_step(term, t2) / 20;  sum = sum + term;
      term = taylor_step(term, t2) / 42;  sum = sum - term;
      term = taylor_step(term, t2) / 72;  sum = sum + term;
      term = taylor_step(term, t2) / 110; sum = sum - term;
      term = taylor_step(term, t2) / 156; sum = sum + term;
      term = taylor_step(term, t2) / 210; sum = sum - term;
      term = taylor_step(term, t2) / 272; sum = sum + term;
      term = taylor_step(term, t2) / 342; sum = sum - term;
      if (sum > ONE_Q30) begin
        sum = ONE_Q30;
      end
      tab[r] = 16'((sum * AMPLITUDE + (ONE_Q30 >> 1)) >> 30);
    end
    return tab;
  endfunction

  localparam qtab_t QTAB = build_qtab();

  function automatic logic signed [15:0] table_sine(input logic [TAB_BITS-1:0] idx);
    logic [1:0]          quad;
    logic [7:0]          r;
    logic signed [15:0]  v;
    quad = idx[TAB_BITS-1 -: 2];
    r = idx[7:0];
    if (quad[0]) begin
      v = QTAB[9'(QUARTER) - {1'b0, r}];
    end else begin
      v = QTAB[{1'b0, r}];
    end
    return quad[1] ? -v : v;
  endfunction

endpackage

@@ sv/mfsk_modulator.sv @@
// A symbol passes through the front's MUL, DIV and PUSH states and the entry queue before its samples start.
// Throughput: one sample per cycle within a symbol unless out_tready stalls the output; the front computes
// the next symbol's increment with a 2-bit-per-cycle divider while the back runs the sample loop.
// Synchronous active-low reset clears the phase, the symbol queue and the output valid flag,
// and loads the registers with their defaults.
module mfsk_modulator import mfsk_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // symbol
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // {quadrature, in_phase}
  output logic        out_tlast,
  output logic        out_tuser,  // symbol_clamped
  input  logic        cfg_wen,
  input  logic [1:0]  cfg_index,
  input  logic [14:0] cfg_wdata
);

  logic [3:0]  bps_r;
  logic [6:0]  sps_r;
  logic [14:0] bw_r;

  mfsk_entry_t f_entry, q_entry;
  logic        f_valid, f_ready, q_valid, q_ready;
  logic [15:0] i_s, q_s;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bps_r <= 4'd1;
      sps_r <= 7'd8;
      bw_r <= 15'd8192;
    end else if (cfg_wen) begin
      unique case (cfg_index)
        CFG_BPS: bps_r <= cfg_wdata[3:0];
        CFG_SPS: sps_r <= cfg_wdata[6:0];
        CFG_BW:  bw_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  mfsk_front u_front (
    .clk(clk), .rst_n(rst_n), .bps(bps_r), .bw(bw_r),
    .sym(in_tdata), .sym_valid(in_tvalid), .sym_ready(in_tready),
    .entry(f_entry), .entry_valid(f_valid), .entry_ready(f_ready)
  );

  mfsk_fifo u_fifo (
    .clk(clk), .rst_n(rst_n),
    .wr_data(f_entry), .wr_valid(f_valid), .wr_ready(f_ready),
    .rd_data(q_entry), .rd_valid(q_valid), .rd_ready(q_ready)
  );

  mfsk_back u_back (
    .clk(clk), .rst_n(rst_n), .sps(sps_r),
    .entry(q_entry), .entry_valid(q_valid), .entry_ready(q_ready),
    .i_out(i_s), .q_out(q_s), .last_out(out_tlast), .clamped_out(out_tuser),
    .out_valid(out_tvalid), .out_ready(out_tready)
  );

  assign out_tdata = {q_s, i_s};

endmodule

@@ sv/mfsk_front.sv @@
module mfsk_front import mfsk_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic [3:0]  bps,
  input  logic [14:0] bw,
  input  logic [7:0]  sym,
  input  logic        sym_valid,
  output logic        sym_ready,
  output mfsk_entry_t entry,
  output logic        entry_valid,
  input  logic        entry_ready
);

  typedef enum logic [1:0] {IDLE, MUL, DIV, PUSH} state_t;

  state_t      state_r;
  logic [7:0]  mmax_r;
  logic [7:0]  d_r;
  logic        neg_r;
  logic        clamped_r;
  logic [39:0] num_r;
  logic [7:0]  rem_r;
  logic [31:0] quo_r;
  logic [4:0]  cnt_r;

  logic [3:0]  m_eff;
  logic [8:0]  mmax9;
  logic [7:0]  mmax;
  logic        clamp;
  logic [8:0]  two_s;
  logic        neg;
  logic [8:0]  d9;
  logic [8:0]  r1, r1s, r2, r2s;
  logic        ge1, ge2;

  always_comb begin
    if (bps == 4'd0) begin
      m_eff = 4'd1;
    end else if (bps > 4'd8) begin
      m_eff = 4'd8;
    end else begin
      m_eff = bps;
    end
    mmax9 = (9'd1 << m_eff) - 9'd1;
    mmax = mmax9[7:0];
    clamp = sym > mmax;
    two_s = clamp ? 9'd0 : {sym, 1'b0};
    neg = two_s < {1'b0, mmax};
    d9 = neg ? ({1'b0, mmax} - two_s) : (two_s - {1'b0, mmax});
    r1 = {rem_r, num_r[39]};
    ge1 = r1 >= {1'b0, mmax_r};
    r1s = ge1 ? (r1 - {1'b0, mmax_r}) : r1;
    r2 = {r1s[7:0], num_r[38]};
    ge2 = r2 >= {1'b0, mmax_r};
    r2s = ge2 ? (r2 - {1'b0, mmax_r}) : r2;
  end

  assign sym_ready = (state_r == IDLE);
  assign entry_valid = (state_r == PUSH);
  assign entry.inc = neg_r ? (32'd0 - quo_r) : quo_r;
  assign entry.clamped = clamped_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= IDLE;
      cnt_r <= '0;
    end else begin
      unique case (state_r)
        IDLE: begin
          if (sym_valid) begin
            mmax_r <= mmax;
            d_r <= d9[7:0];
            neg_r <= neg;
            clamped_r <= clamp;
            state_r <= MUL;
          end
        end
        MUL: begin
          num_r <= {1'b0, {15'd0, d_r} * {8'd0, bw}, 16'd0};
          rem_r <= '0;
          quo_r <= '0;
          cnt_r <= '0;
          state_r <= DIV;
        end
        DIV: begin
          num_r <= {num_r[37:0], 2'b00};
          rem_r <= r2s[7:0];
          quo_r <= {quo_r[29:0], ge1, ge2};
          cnt_r <= cnt_r + 5'd1;
          if (cnt_r == 5'd19) begin
            state_r <= PUSH;
          end
        end
        PUSH: begin
          if (entry_ready) begin
            state_r <= IDLE;
          end
        end
        default: state_r <= IDLE;
      endcase
    end
  end

endmodule

@@ sv/mfsk_fifo.sv @@
module mfsk_fifo import mfsk_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  mfsk_entry_t wr_data,
  input  logic        wr_valid,
  output logic        wr_ready,
  output mfsk_entry_t rd_data,
  output logic        rd_valid,
  input  logic        rd_ready
);

  mfsk_entry_t mem_r [0:1];
  logic        wp_r;
  logic        rp_r;
  logic [1:0]  cnt_r;
  logic        push;
  logic        pop;

  assign wr_ready = (cnt_r != 2'd2);
  assign rd_valid = (cnt_r != 2'd0);
  assign rd_data = mem_r[rp_r];
  assign push = wr_valid && wr_ready;
  assign pop = rd_valid && rd_ready;

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wp_r] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= 1'b0;
      rp_r <= 1'b0;
      cnt_r <= '0;
    end else begin
      if (push) begin
        wp_r <= ~wp_r;
      end
      if (pop) begin
        rp_r <= ~rp_r;
      end
      cnt_r <= cnt_r + {1'b0, push} - {1'b0, pop};
    end
  end

endmodule

@@ sv/mfsk_back.sv @@
module mfsk_back import mfsk_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic [6:0]  sps,
  input  mfsk_entry_t entry,
  input  logic        entry_valid,
  output logic        entry_ready,
  output logic [15:0] i_out,
  output logic [15:0] q_out,
  output logic        last_out,
  output logic        clamped_out,
  output logic        out_valid,
  input  logic        out_ready
);

  logic                  active_r;
  logic [PHASE_BITS-1:0] phase_r;
  logic [PHASE_BITS-1:0] inc_r;
  logic                  clamped_r;
  logic [6:0]            idx_r;
  logic                  valid_r;
  logic [15:0]           i_r, q_r;
  logic                  last_r, clo_r;

  logic [6:0]            k_eff;
  logic [TAB_BITS-1:0]   tidx;
  logic                  emit;
  logic                  is_last;

  always_comb begin
    if (sps < 7'd2) begin
      k_eff = 7'd2;
    end else if (sps > 7'(MAX_SPS)) begin
      k_eff = 7'(MAX_SPS);
    end else begin
      k_eff = sps;
    end
  end

  assign tidx = phase_r[PHASE_BITS-1 -: TAB_BITS];
  assign emit = active_r && (!valid_r || out_ready);
  assign is_last = (idx_r + 7'd1 == k_eff);
  assign entry_ready = !active_r;

  assign i_out = i_r;
  assign q_out = q_r;
  assign last_out = last_r;
  assign clamped_out = clo_r;
  assign out_valid = valid_r;

  always_ff @(posedge clk) begin
    if (emit) begin
      i_r <= table_sine(tidx + TAB_BITS'(QUARTER));
      q_r <= table_sine(tidx);
      last_r <= is_last;
      clo_r <= clamped_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r <= 1'b0;
      phase_r <= '0;
      inc_r <= '0;
      idx_r <= '0;
      valid_r <= 1'b0;
      clamped_r <= 1'b0;
    end else begin
      if (emit) begin
        valid_r <= 1'b1;
        phase_r <= phase_r + inc_r;
        idx_r <= is_last ? 7'd0 : idx_r + 7'd1;
        if (is_last) begin
          active_r <= 1'b0;
        end
      end else if (out_ready) begin
        valid_r <= 1'b0;
      end
      if (!active_r && entry_valid) begin
        active_r <= 1'b1;
        inc_r <= entry.inc;
        clamped_r <= entry.clamped;
        idx_r <= '0;
      end
    end
  end

endmodule

@@ bench/mfsk_modulator_test.sv @@
`timescale 1ns / 100ps

module mfsk_modulator_test;
  import mfsk_pkg::*;

  typedef struct {
    logic signed [15:0] cos_val;
    logic signed [15:0] sin_val;
    logic               last;
    logic               clamped;
  } iq_sample_t;

  class tone_scoreboard;
    logic [3:0]  bits_reg;
    logic [6:0]  sps_reg;
    logic [14:0] bw_reg;
    logic [31:0] phase;
    int          sine_q[0:256];
    iq_sample_t  pending[$];
    int          fails;

    function void build_sine();
      longint unsigned t, t2, term, acc, dv;
      for (int r = 0; r <= 256; r++) begin
        t = (64'd1686629713 * longint'(r)) / 256;
        t2 = (t * t) >> 30;
        term = t;
        acc = t;
        for (int n = 0; n < 9; n++) begin
          dv = (2 * n + 2) * (2 * n + 3);
          term = ((term * t2) >> 30) / dv;
          if (n % 2 == 0) begin
            acc = acc - term;
          end else begin
            acc = acc + term;
          end
        end
        if (acc > (64'd1 << 30)) begin
          acc = 64'd1 << 30;
        end
        sine_q[r] = int'((acc * 32767 + (64'd1 << 29)) >> 30);
      end
    endfunction

    function logic signed [15:0] sine_at(logic [9:0] idx);
      int v;
      v = idx[8] ? sine_q[256 - idx[7:0]] : sine_q[idx[7:0]];
      return idx[9] ? 16'(-v) : 16'(v);
    endfunction

    function void restart();
      bits_reg = 4'd1;
      sps_reg = 7'd8;
      bw_reg = 15'd8192;
      phase = '0;
      pending.delete();
    endfunction

    function void write_reg(logic [1:0] idx, logic [14:0] val);
      case (idx)
        CFG_BPS: bits_reg = val[3:0];
        CFG_SPS: sps_reg = val[6:0];
        CFG_BW:  bw_reg = val;
        default: ;
      endcase
    endfunction

    function int eff_bits();
      if (bits_reg < 1) return 1;
      if (bits_reg > 8) return 8;
      return bits_reg;
    endfunction

    function void note_symbol(logic [7:0] sym);
      int              m, k;
      longint unsigned mmax, s, d, mag;
      logic            clamp, neg;
      logic [31:0]     step;
      iq_sample_t      smp;
      m = eff_bits();
      k = (sps_reg < 2) ? 2 : ((sps_reg > 64) ? 64 : sps_reg);
      mmax = (64'd1 << m) - 1;
      s = sym;
      clamp = 1'b0;
      if (s > mmax) begin
        s = 0;
        clamp = 1'b1;
      end
      neg = (2 * s) < mmax;
      d = neg ? (mmax - 2 * s) : (2 * s - mmax);
      mag = ((d * bw_reg) << 16) / mmax;
      step = neg ? 32'(-mag) : 32'(mag);
      for (int i = 0; i < k; i++) begin
        smp.sin_val = sine_at(phase[31:22]);
        smp.cos_val = sine_at(phase[31:22] + 10'd256);
        smp.last = (i == k - 1);
        smp.clamped = clamp;
        pending.push_back(smp);
        phase = phase + step;
      end
    endfunction

    task report(string msg);
      $display("mismatch at %0t: %s", $time, msg);
      fails++;
    endtask

    task check(logic [31:0] data, logic last, logic user);
      iq_sample_t e;
      if (pending.size() == 0) begin
        report("sample transfer with nothing expected");
        return;
      end
      e = pending.pop_front();
      if (data[15:0] !== e.cos_val)
        report($sformatf("in_phase %0d, expected %0d", $signed(data[15:0]), e.cos_val));
      if (data[31:16] !== e.sin_val)
        report($sformatf("quadrature %0d, expected %0d", $signed(data[31:16]), e.sin_val));
      if (last !== e.last) report($sformatf("tlast %b, expected %b", last, e.last));
      if (user !== e.clamped) report($sformatf("tuser %b, expected %b", user, e.clamped));
    endtask
  endclass

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [7:0]  in_tdata;
  logic        out_tvalid;
  logic        out_tready;
  logic [31:0] out_tdata;
  logic        out_tlast;
  logic        out_tuser;
  logic        cfg_wen;
  logic [1:0]  cfg_index;
  logic [14:0] cfg_wdata;

  tone_scoreboard sb;

  mfsk_modulator dut (.*);

  initial begin
    clk = 0;
    forever #10 clk = ~clk;
  end

  initial begin
    #50ms;
    $display("tb: failure");
    $finish;
  end

  function int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  initial begin
    int g;
    out_tready = 1'b0;
    @(posedge clk iff rst_n);
    forever begin
      out_tready <= 1'b1;
      repeat ($urandom_range(1, 30)) @(posedge clk);
      g = pick_gap();
      if (g > 0) begin
        out_tready <= 1'b0;
        repeat (g) @(posedge clk);
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) sb.check(out_tdata, out_tlast, out_tuser);
  end

  task send_symbol(logic [7:0] sym);
    int g;
    in_tdata <= sym;
    in_tvalid <= 1'b1;
    do @(posedge clk); while (!in_tready);
    sb.note_symbol(sym);
    g = pick_gap();
    if (g > 0) begin
      in_tvalid <= 1'b0;
      repeat (g) @(posedge clk);
    end
  endtask

  task write_cfg(logic [1:0] idx, logic [14:0] val);
    in_tvalid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    cfg_wen <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_wen <= 1'b0;
    sb.write_reg(idx, val);
  endtask

  task random_symbols(int count);
    int top;
    for (int i = 0; i < count; i++) begin
      top = (1 << sb.eff_bits()) - 1;
      if ($urandom_range(0, 9) < 8) send_symbol(8'($urandom_range(0, top)));
      else send_symbol(8'($urandom));
    end
  endtask

  task set_all(logic [14:0] b, logic [14:0] k, logic [14:0] w);
    write_cfg(CFG_BPS, b);
    write_cfg(CFG_SPS, k);
    write_cfg(CFG_BW, w);
  endtask

  initial begin
    sb = new();
    sb.build_sine();
    sb.restart();
    sb.fails = 0;
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    cfg_wen = 1'b0;
    cfg_index = '0;
    cfg_wdata = '0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_symbol(8'd0);
    send_symbol(8'd1);
    send_symbol(8'd255);
    send_symbol(8'd2);
    set_all(15'd8, 15'd64, 15'd32767);
    send_symbol(8'd0);
    send_symbol(8'd255);
    send_symbol(8'd128);
    send_symbol(8'd127);
    set_all(15'd3, 15'd2, 15'd1);
    send_symbol(8'd7);
    send_symbol(8'd8);
    send_symbol(8'd3);
    send_symbol(8'd4);
    set_all(15'd0, 15'd1, 15'd0);
    send_symbol(8'd1);
    send_symbol(8'd2);
    set_all(15'h7fff, 15'h7fff, 15'd12345);
    send_symbol(8'd200);
    send_symbol(8'd255);
    write_cfg(2'd3, 15'h5555);
    send_symbol(8'd85);
    send_symbol(8'd170);

    random_symbols(30);
    set_all(15'd2, 15'd5, 15'($urandom_range(1, 32767)));
    random_symbols(35);
    set_all(15'd4, 15'd16, 15'($urandom_range(1, 32767)));
    random_symbols(35);
    set_all(15'd8, 15'd3, 15'd32767);
    random_symbols(30);
    set_all(15'd1, 15'd64, 15'd1);
    random_symbols(10);
    set_all(15'd6, 15'd10, 15'($urandom_range(1, 32767)));
    random_symbols(40);

    in_tvalid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (60) @(posedge clk);
    if (sb.fails == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
